// File: hw/rtl/skis_pkg.sv
// Shared types and codes for the sorted key index search block.
// No dependencies; imported by skis_store and sorted_key_index_search.
package skis_pkg;

    localparam int KEY_HALF_W = 56;
    localparam int KEY_W      = 2 * KEY_HALF_W;
    localparam int REC_W      = 4;
    localparam int TOT_W      = 5;
    localparam int STAT_W     = 2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [REC_W-1:0] rec;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_LK_RD,
        ST_LK_CMP
    } state_t;

endpackage

// File: hw/rtl/skis_store.sv
// Entry store: one write port and one read port with registered read data.
// Depends on skis_pkg for entry_t.
module skis_store
    import skis_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/sorted_key_index_search.sv
// Sorted key index: insert into a sorted store, binary-search lookup.
// Insert walks down from the top, shifting each larger entry up a slot, then writes the key
// (a full store is answered with STAT_FULL); lookup binary-searches p <= ceil(log2(n+1)) probes.
// Each step is a registered store read followed by a compare.
// One item at a time; done strobes one cycle and cannot be stalled.
// Reset clears control and the entry count; store contents stay undefined.
module sorted_key_index_search
    import skis_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  mode,
    input  logic [KEY_HALF_W-1:0] key_hi,
    input  logic [KEY_HALF_W-1:0] key_lo,
    output logic                  done,
    output logic [STAT_W-1:0]     status,
    output logic [REC_W-1:0]      record_number,
    output logic [TOT_W-1:0]      entry_total
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t            state_reg, state_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [AW-1:0]     mid_reg, mid_next;
    logic [CW-1:0]     low_reg, low_next;
    logic [CW-1:0]     hix_reg, hix_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [REC_W-1:0]  rec_reg, rec_next;
    logic [TOT_W-1:0]  total_reg, total_next;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_data;

    logic              accept;
    logic              is_full;
    logic              range_open;
    logic [CW:0]       mid_sum;
    logic              stored_gt;
    logic              stored_lt;

    skis_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign accept     = start && (state_reg == ST_IDLE);
    assign is_full    = (count_reg >= CW'(DEPTH));
    assign range_open = (low_reg < hix_reg);
    // floor((low + high) / 2) with high = hix - 1; only used while range is open
    assign mid_sum    = {1'b0, low_reg} + {1'b0, hix_reg} - (CW + 1)'(1);
    assign stored_gt  = (rd_data.key > key_reg);
    assign stored_lt  = (rd_data.key < key_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_LOOKUP)
                    begin
                        state_next = ST_LK_RD;
                    end
                    else if (!is_full)
                    begin
                        state_next = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD:
            begin
                state_next = (slot_reg == '0) ? ST_IDLE : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                state_next = stored_gt ? ST_INS_RD : ST_IDLE;
            end
            ST_LK_RD:
            begin
                state_next = range_open ? ST_LK_CMP : ST_IDLE;
            end
            ST_LK_CMP:
            begin
                state_next = (stored_gt || stored_lt) ? ST_LK_RD : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_next    = key_reg;
        slot_next   = slot_reg;
        mid_next    = mid_reg;
        low_next    = low_reg;
        hix_next    = hix_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rec_next    = rec_reg;
        total_next  = total_reg;
        rd_en       = 1'b0;
        rd_addr     = slot_reg - AW'(1);
        wr_en       = 1'b0;
        wr_addr     = slot_reg;
        wr_data     = rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next  = {key_hi, key_lo};
                    slot_next = count_reg[AW-1:0];
                    low_next  = '0;
                    hix_next  = count_reg;
                    if (mode == MODE_INSERT && is_full)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_FULL;
                        rec_next    = '0;
                        total_next  = TOT_W'(count_reg);
                    end
                end
            end
            ST_INS_RD:
            begin
                if (slot_reg == '0)
                begin
                    // bottom reached: new key goes first
                    wr_en       = 1'b1;
                    wr_data.key = key_reg;
                    wr_data.rec = REC_W'(count_reg);
                    count_next  = count_reg + CW'(1);
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    rec_next    = REC_W'(count_reg);
                    total_next  = TOT_W'(count_reg + CW'(1));
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (stored_gt)
                begin
                    // shift larger entry up one slot and keep walking down
                    slot_next = slot_reg - AW'(1);
                end
                else
                begin
                    wr_data.key = key_reg;
                    wr_data.rec = REC_W'(count_reg);
                    count_next  = count_reg + CW'(1);
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    rec_next    = REC_W'(count_reg);
                    total_next  = TOT_W'(count_reg + CW'(1));
                end
            end
            ST_LK_RD:
            begin
                rd_addr = mid_sum[AW:1];
                if (range_open)
                begin
                    rd_en    = 1'b1;
                    mid_next = mid_sum[AW:1];
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NOT_FOUND;
                    rec_next    = '0;
                    total_next  = TOT_W'(count_reg);
                end
            end
            ST_LK_CMP:
            begin
                if (stored_gt)
                begin
                    hix_next = CW'(mid_reg);
                end
                else if (stored_lt)
                begin
                    low_next = CW'(mid_reg) + CW'(1);
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    rec_next    = rd_data.rec;
                    total_next  = TOT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        slot_reg   <= slot_next;
        mid_reg    <= mid_next;
        low_reg    <= low_next;
        hix_reg    <= hix_next;
        status_reg <= status_next;
        rec_reg    <= rec_next;
        total_reg  <= total_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign record_number = rec_reg;
    assign entry_total   = total_reg;

endmodule
